// ===== rtl/core/tcon_pkg.sv =====
// Shared types, constants and codes for the text console cell engine.
// No dependencies; every other file in the block refers to this package.
package tcon_pkg;

  localparam int MAX_COLS    = 128;
  localparam int MAX_ROWS    = 64;
  localparam int MIN_COLS    = 20;
  localparam int MIN_ROWS    = 10;
  localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SPAN_W      = $clog2(STORE_DEPTH + 1);
  localparam int COL_W       = 8;
  localparam int ROW_W       = 6;
  localparam int ROWS_W      = 7;
  localparam int BYTE_W      = 8;
  localparam int CELL_W      = 16;
  localparam int REG_IDX_W   = 2;
  localparam int REG_DATA_W  = 8;

  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;
  localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF      = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_BS      = 8'h08;
  localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [COL_W:0]    TAB_STEP   = 9'd8;

  localparam logic [REG_IDX_W-1:0] REG_COLUMNS   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TEXT_ATTR = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_STEADY    = 2'd3;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic              op;
    logic [BYTE_W-1:0] byte_in;
    logic [BYTE_W-1:0] read_row;
    logic [BYTE_W-1:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
    logic [ADDR_W-1:0] cur_pos;
    logic [BYTE_W-1:0] read_char;
    logic [BYTE_W-1:0] read_attr;
  } out_item_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_LIFT_RD,
    S_LIFT_WR,
    S_DECODE,
    S_SCROLL,
    S_DRAIN,
    S_SETTLE1,
    S_PUT,
    S_SETTLE2,
    S_PAINT_RD,
    S_PAINT_WR,
    S_RD_ADDR,
    S_RD_MEM,
    S_RD_DATA,
    S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LATCH,
    CMD_CHECK,
    CMD_LIFT_RD,
    CMD_LIFT_WR,
    CMD_DECODE,
    CMD_SCROLL,
    CMD_PUT,
    CMD_PAINT_RD,
    CMD_PAINT_WR,
    CMD_RD_ADDR,
    CMD_RD_MEM,
    CMD_RD_DATA,
    CMD_EMIT
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_put;
    logic read_in_range;
    logic scroll_needed;
    logic scroll_last;
    logic paint_ok;
  } dp_status_t;

endpackage

// ===== rtl/core/tcon_ctrl.sv =====
// Sequencing state machine for the text console cell engine.
// Depends on tcon_pkg; drives tcon_datapath through command and status signals.
module tcon_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  tcon_pkg::dp_status_t status,
  output tcon_pkg::dp_cmd_t   cmd,
  output logic                busy
);

  tcon_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcon_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = tcon_pkg::CMD_NONE;
    unique case (state)
      tcon_pkg::S_CLEAR: begin
        cmd = tcon_pkg::CMD_CLEAR;
        if (status.clear_last) state_next = tcon_pkg::S_IDLE;
      end
      tcon_pkg::S_IDLE: begin
        if (start) begin
          cmd        = tcon_pkg::CMD_LATCH;
          state_next = tcon_pkg::S_CHECK;
        end
      end
      tcon_pkg::S_CHECK: begin
        cmd = tcon_pkg::CMD_CHECK;
        if (status.is_put || status.read_in_range) state_next = tcon_pkg::S_LIFT_RD;
        else state_next = tcon_pkg::S_EMIT;
      end
      tcon_pkg::S_LIFT_RD: begin
        cmd        = tcon_pkg::CMD_LIFT_RD;
        state_next = tcon_pkg::S_LIFT_WR;
      end
      tcon_pkg::S_LIFT_WR: begin
        cmd = tcon_pkg::CMD_LIFT_WR;
        if (status.is_put) state_next = tcon_pkg::S_DECODE;
        else state_next = tcon_pkg::S_RD_ADDR;
      end
      tcon_pkg::S_DECODE: begin
        cmd = tcon_pkg::CMD_DECODE;
        if (status.scroll_needed) state_next = tcon_pkg::S_SCROLL;
        else state_next = tcon_pkg::S_SETTLE1;
      end
      tcon_pkg::S_SCROLL: begin
        cmd = tcon_pkg::CMD_SCROLL;
        if (status.scroll_last) state_next = tcon_pkg::S_DRAIN;
      end
      tcon_pkg::S_DRAIN: begin
        state_next = tcon_pkg::S_SETTLE1;
      end
      tcon_pkg::S_SETTLE1: begin
        state_next = tcon_pkg::S_PUT;
      end
      tcon_pkg::S_PUT: begin
        cmd        = tcon_pkg::CMD_PUT;
        state_next = tcon_pkg::S_SETTLE2;
      end
      tcon_pkg::S_SETTLE2: begin
        if (status.paint_ok) state_next = tcon_pkg::S_PAINT_RD;
        else state_next = tcon_pkg::S_EMIT;
      end
      tcon_pkg::S_PAINT_RD: begin
        cmd        = tcon_pkg::CMD_PAINT_RD;
        state_next = tcon_pkg::S_PAINT_WR;
      end
      tcon_pkg::S_PAINT_WR: begin
        cmd        = tcon_pkg::CMD_PAINT_WR;
        state_next = tcon_pkg::S_EMIT;
      end
      tcon_pkg::S_RD_ADDR: begin
        cmd        = tcon_pkg::CMD_RD_ADDR;
        state_next = tcon_pkg::S_RD_MEM;
      end
      tcon_pkg::S_RD_MEM: begin
        cmd        = tcon_pkg::CMD_RD_MEM;
        state_next = tcon_pkg::S_RD_DATA;
      end
      tcon_pkg::S_RD_DATA: begin
        cmd        = tcon_pkg::CMD_RD_DATA;
        state_next = tcon_pkg::S_EMIT;
      end
      tcon_pkg::S_EMIT: begin
        cmd        = tcon_pkg::CMD_EMIT;
        state_next = tcon_pkg::S_IDLE;
      end
      default: begin
        state_next = tcon_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state != tcon_pkg::S_IDLE);

endmodule

// ===== rtl/core/tcon_datapath.sv =====
// Datapath of the text console cell engine: cell store, cursor, geometry and paint state.
// Depends on tcon_pkg; acts on commands from tcon_ctrl and returns status.
module tcon_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  tcon_pkg::dp_cmd_t                   cmd,
  input  tcon_pkg::in_item_t                  item,
  input  logic                                wr_en,
  input  logic [tcon_pkg::REG_IDX_W-1:0]      wr_index,
  input  logic [tcon_pkg::REG_DATA_W-1:0]     wr_data,
  output tcon_pkg::dp_status_t                status,
  output logic                                done,
  output tcon_pkg::out_item_t                 result
);

  localparam int AW = tcon_pkg::ADDR_W;
  localparam int SW = tcon_pkg::SPAN_W;
  localparam int CW = tcon_pkg::COL_W;
  localparam int RW = tcon_pkg::ROW_W;
  localparam int NW = tcon_pkg::ROWS_W;
  localparam int BW = tcon_pkg::BYTE_W;
  localparam int DW = tcon_pkg::CELL_W;

  logic [CW-1:0] columns;
  logic [NW-1:0] row_count;
  logic [BW-1:0] text_attr;
  logic          steady_cursor;

  logic [DW-1:0] mem [tcon_pkg::STORE_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;

  logic [RW-1:0] cursor_row;
  logic [CW-1:0] cursor_col;
  logic          soft_active;
  logic [AW-1:0] soft_index;
  logic [DW-1:0] soft_painted;
  logic [DW-1:0] soft_saved;
  logic          lift_go;

  logic          op_q;
  logic [BW-1:0] byte_q;
  logic [BW-1:0] rrow_q;
  logic [BW-1:0] rcol_q;
  logic [BW-1:0] hold_char;
  logic [BW-1:0] hold_attr;

  logic [SW-1:0] lim_q;
  logic [AW-1:0] last_q;
  logic [AW-1:0] pos_q;
  logic [AW-1:0] rd_addr;
  logic [SW-1:0] scan;
  logic          wr_pend;
  logic [AW-1:0] wr_addr;
  logic          wr_blank;

  logic [CW-1:0] gcols;
  logic [NW-1:0] grows;
  logic [CW:0]   gcols9;
  logic [DW-1:0] blank;
  logic          is_cr, is_lf, is_bs, is_tab, printable;
  logic [CW:0]   tab_col;
  logic          new_line;
  logic [NW-1:0] row_inc;
  logic          row_wrap;
  logic          row_in;
  logic          col_in;
  logic          put_ok;
  logic [CW:0]   col_inc;
  logic          lift_ok;
  logic [DW-1:0] swapped;

  always_comb begin
    if (columns < CW'(tcon_pkg::MIN_COLS)) gcols = CW'(tcon_pkg::MIN_COLS);
    else if (columns > CW'(tcon_pkg::MAX_COLS)) gcols = CW'(tcon_pkg::MAX_COLS);
    else gcols = columns;
    if (row_count < NW'(tcon_pkg::MIN_ROWS)) grows = NW'(tcon_pkg::MIN_ROWS);
    else if (row_count > NW'(tcon_pkg::MAX_ROWS)) grows = NW'(tcon_pkg::MAX_ROWS);
    else grows = row_count;
  end

  assign gcols9    = {1'b0, gcols};
  assign blank     = {text_attr, tcon_pkg::CH_SPACE};
  assign is_cr     = (byte_q == tcon_pkg::CH_CR);
  assign is_lf     = (byte_q == tcon_pkg::CH_LF);
  assign is_bs     = (byte_q == tcon_pkg::CH_BS);
  assign is_tab    = (byte_q == tcon_pkg::CH_TAB);
  assign printable = !(is_cr || is_lf || is_bs || is_tab);
  assign tab_col   = ({1'b0, cursor_col} + tcon_pkg::TAB_STEP) & ~(tcon_pkg::TAB_STEP - 9'd1);
  assign new_line  = is_lf || (is_tab && (tab_col >= gcols9)) ||
                     (printable && (cursor_col >= gcols));
  assign row_inc   = {1'b0, cursor_row} + NW'(1);
  assign row_wrap  = (row_inc >= grows);
  assign row_in    = ({1'b0, cursor_row} < grows);
  assign col_in    = (cursor_col < gcols);
  assign put_ok    = printable && row_in && col_in;
  assign col_inc   = {1'b0, cursor_col} + {{CW{1'b0}}, printable};
  assign lift_ok   = lift_go && ({1'b0, soft_index} < lim_q) && (mem_rdata == soft_painted);
  assign swapped   = {mem_rdata[11:8], mem_rdata[15:12], mem_rdata[7:0]};

  always_comb begin
    status.clear_last    = (scan[AW-1:0] == {AW{1'b1}});
    status.is_put        = (op_q == tcon_pkg::OP_PUT);
    status.read_in_range = (rrow_q < {1'b0, grows}) && (rcol_q < gcols);
    status.scroll_needed = new_line && row_wrap;
    status.scroll_last   = (scan == lim_q - SW'(1));
    status.paint_ok      = steady_cursor && row_in && col_in;
  end

  always_comb begin
    unique case (cmd)
      tcon_pkg::CMD_LIFT_RD:  mem_raddr = soft_index;
      tcon_pkg::CMD_SCROLL:   mem_raddr = AW'(scan + SW'(gcols));
      tcon_pkg::CMD_RD_MEM:   mem_raddr = rd_addr;
      default:                mem_raddr = pos_q;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos_q;
    mem_wdata = swapped;
    priority if (wr_pend) begin
      mem_we    = 1'b1;
      mem_waddr = wr_addr;
      mem_wdata = wr_blank ? blank : mem_rdata;
    end else if (cmd == tcon_pkg::CMD_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = scan[AW-1:0];
      mem_wdata = tcon_pkg::RESET_CELL;
    end else if (cmd == tcon_pkg::CMD_LIFT_WR) begin
      mem_we    = lift_ok;
      mem_waddr = soft_index;
      mem_wdata = soft_saved;
    end else if (cmd == tcon_pkg::CMD_PUT) begin
      mem_we    = put_ok;
      mem_wdata = {text_attr, byte_q};
    end else if (cmd == tcon_pkg::CMD_PAINT_WR) begin
      mem_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    lim_q   <= SW'(SW'(gcols) * SW'(grows));
    last_q  <= AW'(SW'(gcols) * SW'(grows - NW'(1)));
    pos_q   <= AW'(SW'(cursor_row) * SW'(gcols) + SW'(cursor_col));
    wr_addr <= scan[AW-1:0];
    wr_blank <= (scan >= {1'b0, last_q});
    if (cmd == tcon_pkg::CMD_LATCH) begin
      op_q   <= item.op;
      byte_q <= item.byte_in;
      rrow_q <= item.read_row;
      rcol_q <= item.read_col;
    end
    if (cmd == tcon_pkg::CMD_RD_ADDR) begin
      rd_addr <= AW'(SW'(rrow_q) * SW'(gcols) + SW'(rcol_q));
    end
    if (cmd == tcon_pkg::CMD_CHECK) begin
      if (op_q == tcon_pkg::OP_READ && !status.read_in_range) begin
        hold_char <= tcon_pkg::CH_SPACE;
        hold_attr <= text_attr;
      end else begin
        hold_char <= '0;
        hold_attr <= '0;
      end
    end
    if (cmd == tcon_pkg::CMD_RD_DATA) begin
      hold_char <= mem_rdata[7:0];
      hold_attr <= mem_rdata[15:8];
    end
    if (cmd == tcon_pkg::CMD_EMIT) begin
      result.cur_row   <= cursor_row;
      result.cur_col   <= cursor_col;
      result.cur_pos   <= pos_q;
      result.read_char <= hold_char;
      result.read_attr <= hold_attr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      columns       <= CW'(80);
      row_count     <= NW'(25);
      text_attr     <= BW'(7);
      steady_cursor <= 1'b0;
      cursor_row    <= '0;
      cursor_col    <= '0;
      soft_active   <= 1'b0;
      soft_index    <= '0;
      soft_painted  <= '0;
      soft_saved    <= '0;
      lift_go       <= 1'b0;
      scan          <= '0;
      wr_pend       <= 1'b0;
      done          <= 1'b0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          tcon_pkg::REG_COLUMNS:   columns       <= wr_data;
          tcon_pkg::REG_ROW_COUNT: row_count     <= wr_data[NW-1:0];
          tcon_pkg::REG_TEXT_ATTR: text_attr     <= wr_data;
          tcon_pkg::REG_STEADY:    steady_cursor <= wr_data[0];
          default: ;
        endcase
      end
      wr_pend <= (cmd == tcon_pkg::CMD_SCROLL);
      done    <= (cmd == tcon_pkg::CMD_EMIT);
      unique case (cmd)
        tcon_pkg::CMD_CLEAR: begin
          scan <= (scan[AW-1:0] == {AW{1'b1}}) ? '0 : scan + SW'(1);
        end
        tcon_pkg::CMD_LIFT_RD: begin
          lift_go     <= soft_active;
          soft_active <= 1'b0;
        end
        tcon_pkg::CMD_DECODE: begin
          scan <= '0;
          if (new_line) begin
            cursor_col <= '0;
            cursor_row <= row_wrap ? RW'(grows - NW'(1)) : row_inc[RW-1:0];
          end else if (is_cr) begin
            cursor_col <= '0;
          end else if (is_bs) begin
            if (cursor_col != '0) cursor_col <= cursor_col - CW'(1);
          end else if (is_tab) begin
            cursor_col <= tab_col[CW-1:0];
          end
        end
        tcon_pkg::CMD_SCROLL: begin
          scan <= scan + SW'(1);
        end
        tcon_pkg::CMD_PUT: begin
          cursor_col <= (col_inc > gcols9) ? gcols : col_inc[CW-1:0];
          if (!row_in) cursor_row <= RW'(grows - NW'(1));
        end
        tcon_pkg::CMD_PAINT_WR: begin
          soft_index   <= pos_q;
          soft_saved   <= mem_rdata;
          soft_painted <= swapped;
          soft_active  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/text_console_cell_engine.sv =====
// Top level: a put passes the decode and put states, plus a scroll when needed and the
// cursor paint when enabled; in-range reads pass read address, memory and data states.
// One item at a time; busy is low again in the cycle in which the result strobe is high.
// Reset (rst, synchronous) starts a clearing pass over all 8192 cells of the cell store
// with busy high; configuration writes are taken during it. The receiver cannot stall.
module text_console_cell_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  tcon_pkg::in_item_t              item,
  input  logic                            wr_en,
  input  logic [tcon_pkg::REG_IDX_W-1:0]  wr_index,
  input  logic [tcon_pkg::REG_DATA_W-1:0] wr_data,
  output logic                            done,
  output tcon_pkg::out_item_t             result
);

  tcon_pkg::dp_cmd_t    cmd;
  tcon_pkg::dp_status_t status;

  tcon_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  tcon_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .item     (item),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .status   (status),
    .done     (done),
    .result   (result)
  );

endmodule
